FILE: hdl/wwcl_pkg.sv
// Shared constants, codes and types for the word wrap centering layout block.
// No dependencies; every other file in hdl except wwcl_ram imports this package.

package wwcl_pkg;

    // Layout limits.
    localparam int MAX_WIDTH = 20;
    localparam int MAX_ROWS  = 4;

    // Configuration register widths and the port that writes them.
    localparam int CFG_W_BITS = 5;
    localparam int CFG_H_BITS = 3;
    localparam int CFG_DW     = 5;
    localparam int CFG_IW     = 1;

    // Character buffer: a circular RAM that holds up to MAX_WIDTH + 1 characters.
    localparam int BUF_AW    = $clog2(MAX_WIDTH + 1);
    localparam int BUF_DEPTH = 1 << BUF_AW;
    localparam int FILL_W    = $clog2(MAX_WIDTH + 2);
    localparam int ROW_W     = $clog2(MAX_ROWS + 1);

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Result kinds.
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_PUT   = 2'd1;
    localparam logic [1:0] KIND_NOCFG = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] row;
        logic [4:0] column;
        logic [7:0] glyph;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // latch the input request
        logic prod_clear;   // produce a clear result, mark text started
        logic prod_notcfg;  // produce a not-configured result, start discarding
        logic write_char;   // append the latched character to the buffer
        logic start_search; // search index = width
        logic idx_dec;      // step the search back by one
        logic found_line;   // line ends before the space at the search index
        logic hard_line;    // line is cut at the width
        logic flush_line;   // line is the whole buffer
        logic row_discard;  // rows exhausted: drop the buffer, start discarding
        logic line_start;   // compute the start column, index = 0
        logic prod_put;     // produce a put-character result
        logic idx_inc;      // next character of the line
        logic line_done;    // consume the line, advance the row
        logic finish;       // release the held result as last, close the text on end
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_text;
        logic disc;
        logic cfg_zero;
        logic end_flag;
        logic fill_gt_w;
        logic fill_nz;
        logic is_space;
        logic idx_one;
        logic idx_last;
        logic row_full;
        logic can_produce;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/word_wrap_centering_layout.sv
// Top level of the word wrap centering layout block.
// Depends on wwcl_pkg, wwcl_ctrl, wwcl_dp (which holds wwcl_ram).

// Text arrives one character per request on the s_ channel, with s_tlast on
// the final character of a text, and leaves as display commands on the m_
// channel: a clear at the first character, then the characters of each wrapped
// line as put-character commands, centered at column (width - length) / 2 on
// successive rows, or one not-configured command when the width or height
// register is zero. m_tlast marks the final command caused by each request,
// and a request may cause none. Lines wrap greedily at the last space within
// the width, which is dropped; a word longer than the width is cut at the
// width. Rows beyond the height are dropped along with the rest of the text.
// The controller finishes one request before it accepts the next. For each
// line it puts out, it examines buffer positions from the width back to the
// space when the buffer is split, then reads and puts out each character; both
// steps go through the registered read port of the character buffer RAM, which
// serves one character per read. A command waits while the output is stalled.
// The input is taken only between requests, while a finished command may still
// wait in the output register.
// Write the width and height registers only while the block is idle.

module word_wrap_centering_layout (
    input  logic                        aclk,
    input  logic                        aresetn,

    // Configuration: index 0 screen width, index 1 screen height.
    input  logic                        cfg_wr_en,
    input  logic [wwcl_pkg::CFG_IW-1:0] cfg_index,
    input  logic [wwcl_pkg::CFG_DW-1:0] cfg_wdata,

    // Input requests.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] text_char
    input  logic                        s_tlast,   // end_of_text

    // Result requests.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [1:0] row, [6:2] column,
                                                   // [14:7] glyph, [15] zero
    output logic [1:0]                  m_tuser,   // [1:0] kind
    output logic                        m_tlast    // last
);

    import wwcl_pkg::*;

    cmd_t cmd;
    sts_t sts;
    res_t m_res;

    wwcl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wwcl_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_char   (s_tdata),
        .in_end    (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res),
        .m_tlast   (m_tlast)
    );

    // Pack the result fields onto the stream bus.
    assign m_tdata = {1'b0, m_res.glyph, m_res.column, m_res.row};
    assign m_tuser = m_res.kind;

`ifndef SYNTHESIS
    // Between requests no result may be held back, or its last flag would be lost.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.pend_valid)
        else $error("result held back while the input is open");

    // The controller produces a result only when the held slot can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.prod_clear || cmd.prod_notcfg || cmd.prod_put) |-> sts.can_produce)
        else $error("result produced while the held slot was blocked");

    // An accepted request closes the input until its work is done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened right after a request");

    // Clear and not-configured results carry no placement.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != KIND_PUT)) |-> (m_tdata == '0))
        else $error("placement fields set on a non-put result");
`endif

endmodule

FILE: hdl/wwcl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module wwcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/wwcl_ctrl.sv
// Controller state machine of the word wrap centering layout block.
// Depends on wwcl_pkg; drives the datapath only through cmd_t and reads sts_t.

module wwcl_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  wwcl_pkg::sts_t sts,
    output wwcl_pkg::cmd_t cmd
);

    import wwcl_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_TAKE   = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_SRD    = 4'd4;
    localparam logic [3:0] S_SCMP   = 4'd5;
    localparam logic [3:0] S_LINE   = 4'd6;
    localparam logic [3:0] S_ERD    = 4'd7;
    localparam logic [3:0] S_EPUT   = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (sts.in_text) begin
                    state_next = S_TAKE;
                end else if (sts.can_produce) begin
                    cmd.prod_clear = 1'b1;
                    state_next     = S_TAKE;
                end
            end
            S_TAKE: begin
                if (sts.disc) begin
                    state_next = S_FINISH;
                end else if (sts.cfg_zero) begin
                    if (sts.can_produce) begin
                        cmd.prod_notcfg = 1'b1;
                        state_next      = S_FINISH;
                    end
                end else begin
                    cmd.write_char = 1'b1;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!sts.disc && sts.fill_gt_w) begin
                    cmd.start_search = 1'b1;
                    state_next       = S_SRD;
                end else if (sts.end_flag && !sts.disc && sts.fill_nz) begin
                    cmd.flush_line = 1'b1;
                    state_next     = S_LINE;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SRD: begin
                state_next = S_SCMP;
            end
            S_SCMP: begin
                if (sts.is_space) begin
                    cmd.found_line = 1'b1;
                    state_next     = S_LINE;
                end else if (sts.idx_one) begin
                    cmd.hard_line = 1'b1;
                    state_next    = S_LINE;
                end else begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_LINE: begin
                if (sts.row_full) begin
                    cmd.row_discard = 1'b1;
                    state_next      = S_FINISH;
                end else begin
                    cmd.line_start = 1'b1;
                    state_next     = S_ERD;
                end
            end
            S_ERD: begin
                state_next = S_EPUT;
            end
            S_EPUT: begin
                if (sts.can_produce) begin
                    cmd.prod_put = 1'b1;
                    if (sts.idx_last) begin
                        cmd.line_done = 1'b1;
                        state_next    = S_CHECK;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_ERD;
                    end
                end
            end
            S_FINISH: begin
                if (!sts.pend_valid || sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/wwcl_dp.sv
// Datapath of the word wrap centering layout block: configuration, text state,
// the circular character buffer, the held result and the output register.
// Depends on wwcl_pkg and wwcl_ram.

module wwcl_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [wwcl_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [wwcl_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic [7:0]                    in_char,
    input  logic                          in_end,
    input  wwcl_pkg::cmd_t                cmd,
    output wwcl_pkg::sts_t                sts,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output wwcl_pkg::res_t                m_res,
    output logic                          m_tlast
);

    import wwcl_pkg::*;

    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    logic [CFG_W_BITS-1:0] w_eff;
    logic [CFG_H_BITS-1:0] h_eff;

    logic [7:0]            char_reg;
    logic                  end_reg;
    logic [BUF_AW-1:0]     head_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [ROW_W-1:0]      row_reg;
    logic                  in_text_reg;
    logic                  disc_reg;
    logic [CFG_W_BITS-1:0] idx_reg;
    logic [FILL_W-1:0]     len_reg;
    logic [FILL_W-1:0]     cons_reg;
    logic [CFG_W_BITS-1:0] col_base_reg;

    res_t                  pend_reg;
    logic                  pend_valid_reg;
    res_t                  out_reg;
    logic                  out_valid_reg;
    logic                  out_last_reg;

    logic [BUF_AW-1:0]     raddr;
    logic [BUF_AW-1:0]     waddr;
    logic [7:0]            rdata;
    logic                  produce;
    res_t                  new_res;
    logic                  out_free;

    assign w_eff = (int'(width_reg) > MAX_WIDTH) ? CFG_W_BITS'(MAX_WIDTH) : width_reg;
    assign h_eff = (int'(height_reg) > MAX_ROWS) ? CFG_H_BITS'(MAX_ROWS) : height_reg;

    assign raddr = head_reg + BUF_AW'(idx_reg);
    assign waddr = head_reg + BUF_AW'(fill_reg);

    wwcl_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .aclk  (aclk),
        .we    (cmd.write_char),
        .waddr (waddr),
        .wdata (char_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_wdata[CFG_W_BITS-1:0];
                REG_HEIGHT: height_reg <= cfg_wdata[CFG_H_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input request payload.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            char_reg <= in_char;
            end_reg  <= in_end;
        end
    end

    // Text state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            fill_reg    <= '0;
            row_reg     <= '0;
            in_text_reg <= 1'b0;
            disc_reg    <= 1'b0;
        end else begin
            if (cmd.prod_clear) begin
                in_text_reg <= 1'b1;
            end
            if (cmd.prod_notcfg || cmd.row_discard) begin
                disc_reg <= 1'b1;
                fill_reg <= '0;
            end
            if (cmd.write_char) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (cmd.line_done) begin
                head_reg <= head_reg + BUF_AW'(cons_reg);
                fill_reg <= fill_reg - cons_reg;
                row_reg  <= row_reg + ROW_W'(1);
            end
            if (cmd.finish && end_reg) begin
                fill_reg    <= '0;
                row_reg     <= '0;
                in_text_reg <= 1'b0;
                disc_reg    <= 1'b0;
            end
        end
    end

    // Search and line counters.
    always_ff @(posedge aclk) begin
        if (cmd.start_search) begin
            idx_reg <= w_eff;
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_reg - CFG_W_BITS'(1);
        end else if (cmd.line_start) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CFG_W_BITS'(1);
        end

        if (cmd.found_line) begin
            len_reg  <= FILL_W'(idx_reg);
            cons_reg <= FILL_W'(idx_reg) + FILL_W'(1);
        end else if (cmd.hard_line) begin
            len_reg  <= FILL_W'(w_eff);
            cons_reg <= FILL_W'(w_eff);
        end else if (cmd.flush_line) begin
            len_reg  <= fill_reg;
            cons_reg <= fill_reg;
        end

        if (cmd.line_start) begin
            col_base_reg <= (w_eff - CFG_W_BITS'(len_reg)) >> 1;
        end
    end

    // New result; row, column and glyph stay zero for the other kinds.
    always_comb begin
        new_res = '0;
        if (cmd.prod_clear) begin
            new_res.kind = KIND_CLEAR;
        end else if (cmd.prod_notcfg) begin
            new_res.kind = KIND_NOCFG;
        end else begin
            new_res.kind   = KIND_PUT;
            new_res.row    = row_reg[1:0];
            new_res.column = col_base_reg + idx_reg;
            new_res.glyph  = rdata;
        end
    end

    assign produce  = cmd.prod_clear || cmd.prod_notcfg || cmd.prod_put;
    assign out_free = !out_valid_reg || m_tready;

    // One result is held back until it is known whether another follows it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (produce) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.finish) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            pend_reg <= new_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pend_valid_reg && (produce || cmd.finish)) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_valid_reg && (produce || cmd.finish)) begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.finish;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;
    assign m_tlast  = out_last_reg;

    assign sts.in_text     = in_text_reg;
    assign sts.disc        = disc_reg;
    assign sts.cfg_zero    = (w_eff == '0) || (h_eff == '0);
    assign sts.end_flag    = end_reg;
    assign sts.fill_gt_w   = int'(fill_reg) > int'(w_eff);
    assign sts.fill_nz     = (fill_reg != '0);
    assign sts.is_space    = (rdata == SPACE_CHAR);
    assign sts.idx_one     = (idx_reg == CFG_W_BITS'(1));
    assign sts.idx_last    = (int'(idx_reg) + 1 == int'(len_reg));
    assign sts.row_full    = int'(row_reg) >= int'(h_eff);
    assign sts.can_produce = !pend_valid_reg || out_free;
    assign sts.pend_valid  = pend_valid_reg;
    assign sts.out_free    = out_free;

endmodule
